// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// property whose consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/sip_lex_pkg.sv
`timescale 1ns / 1ps

package sip_lex_pkg;

    localparam logic [1:0] VERDICT_PEND = 2'd0;
    localparam logic [1:0] VERDICT_GOOD = 2'd1;
    localparam logic [1:0] VERDICT_BAD  = 2'd2;

    localparam logic [2:0] ROLE_NONE   = 3'd0;
    localparam logic [2:0] ROLE_METHOD = 3'd1;
    localparam logic [2:0] ROLE_URI    = 3'd2;
    localparam logic [2:0] ROLE_NAME   = 3'd3;
    localparam logic [2:0] ROLE_VALUE  = 3'd4;
    localparam logic [2:0] ROLE_REASON = 3'd5;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_US    = 8'h1f;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5a;
    localparam logic [7:0] CASE_BIT = 8'h20;

    localparam logic [7:0] VER_MAX = 8'd255;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } item_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [2:0]  byte_role;
        logic [7:0]  role_byte;
        logic        header_start;
        logic [7:0]  version_major;
        logic [7:0]  version_minor;
        logic [9:0]  status_code;
        logic [31:0] bytes_consumed;
    } result_t;

    function automatic logic is_ctl(input logic [7:0] b);
        return (b <= CH_US) || (b == CH_DEL);
    endfunction

    function automatic logic is_special(input logic [7:0] b);
        logic hit;
        case (b)
            8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40,
            8'h2c, 8'h3b, 8'h3a, 8'h5c, 8'h22,
            8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d,
            8'h7b, 8'h7d, 8'h20, 8'h09: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic is_token(input logic [7:0] b);
        return !b[7] && !is_ctl(b) && !is_special(b);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // acc * 10 + digit, clamped to the byte range
    function automatic logic [7:0] sat_acc(input logic [7:0] acc, input logic [7:0] b);
        logic [11:0] sum;
        sum = {4'd0, acc} * 12'd10 + {8'd0, b[3:0]};
        return (sum > {4'd0, VER_MAX}) ? VER_MAX : sum[7:0];
    endfunction

endpackage

// File: sv/sip_message_head_lexer.sv
`timescale 1ns / 1ps
// SIP message head lexer: takes one byte of a SIP message head per transaction and returns
// one result per byte, with the byte's role, its verdict (pending, head good, bad byte) and
// the version, status and byte count so far. A byte can be accepted in every clock cycle while
// the result channel keeps up; its result appears in the output register in the cycle after
// acceptance. The next byte is taken only while the output register is empty or its result
// is accepted in that cycle, so a stalled result channel holds the input back. The mode bit
// cfg_data is set via the configuration channel; restart uses it, and reset clears it.

`include "assert_macros.svh"

module sip_message_head_lexer
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  sip_lex_pkg::item_t   item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output sip_lex_pkg::result_t result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);

    typedef enum logic [4:0] {
        ST_METHOD_START = 5'd0,
        ST_METHOD       = 5'd1,
        ST_URI          = 5'd2,
        ST_VER_S        = 5'd3,
        ST_VER_I        = 5'd4,
        ST_VER_P        = 5'd5,
        ST_VER_SLASH    = 5'd6,
        ST_MAJ_START    = 5'd7,
        ST_MAJ          = 5'd8,
        ST_MIN_START    = 5'd9,
        ST_MIN          = 5'd10,
        ST_STAT1        = 5'd11,
        ST_STAT2        = 5'd12,
        ST_STAT3        = 5'd13,
        ST_STAT_END     = 5'd14,
        ST_REASON       = 5'd15,
        ST_NL1          = 5'd16,
        ST_LINE_START   = 5'd17,
        ST_LWS          = 5'd18,
        ST_NAME         = 5'd19,
        ST_SPACE        = 5'd20,
        ST_VALUE        = 5'd21,
        ST_NL2          = 5'd22,
        ST_NL3          = 5'd23
    } lex_state_t;

    lex_state_t           state_reg, state_next, state_cur;
    logic                 mode_reg;
    logic [7:0]           major_reg, major_next, major_cur;
    logic [7:0]           minor_reg, minor_next, minor_cur;
    logic [9:0]           status_reg, status_next, status_cur;
    logic                 seen_reg, seen_next, seen_cur;
    logic [31:0]          count_reg, count_next;
    logic                 result_valid_reg;
    sip_lex_pkg::result_t result_reg, result_next;

    logic [7:0]  b;
    logic [1:0]  verdict;
    logic [2:0]  role;
    logic        hstart;
    logic [7:0]  rbyte;
    logic [13:0] stat_sum;
    logic [24:0] stat_prod;
    logic [13:0] stat_rem;
    logic [9:0]  stat_mod;
    logic        take;

    assign take         = item_valid && item_ready;
    assign item_ready   = !result_valid_reg || result_ready;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // status digit shift with a reciprocal modulo 1000
    always_comb
    begin
        stat_sum  = {4'd0, status_cur} * 14'd10 + {10'd0, b[3:0]};
        stat_prod = {11'd0, stat_sum} * 25'd1048;
        stat_rem  = stat_sum - {9'd0, stat_prod[24:20]} * 14'd1000;
        if (stat_rem >= 14'd1000)
        begin
            stat_rem = stat_rem - 14'd1000;
        end
        stat_mod = stat_rem[9:0];
    end

    always_comb
    begin
        b = item.data_byte;
        if (item.restart)
        begin
            state_cur  = mode_reg ? ST_VER_S : ST_METHOD_START;
            major_cur  = 8'd0;
            minor_cur  = 8'd0;
            status_cur = 10'd0;
            seen_cur   = 1'b0;
        end
        else
        begin
            state_cur  = state_reg;
            major_cur  = major_reg;
            minor_cur  = minor_reg;
            status_cur = status_reg;
            seen_cur   = seen_reg;
        end

        state_next  = state_cur;
        major_next  = major_cur;
        minor_next  = minor_cur;
        status_next = status_cur;
        seen_next   = seen_cur;
        count_next  = count_reg + 32'd1;
        verdict     = sip_lex_pkg::VERDICT_PEND;
        role        = sip_lex_pkg::ROLE_NONE;
        hstart      = 1'b0;

        case (state_cur)
            ST_METHOD_START:
            begin
                if (!sip_lex_pkg::is_token(b))
                begin
                    verdict = sip_lex_pkg::VERDICT_BAD;
                end
                else
                begin
                    state_next = ST_METHOD;
                    role       = sip_lex_pkg::ROLE_METHOD;
                end
            end
            ST_METHOD:
            begin
                if (b == sip_lex_pkg::CH_SP)
                begin
                    state_next = ST_URI;
                end
                else if (!sip_lex_pkg::is_token(b))
                begin
                    verdict = sip_lex_pkg::VERDICT_BAD;
                end
                else
                begin
                    role = sip_lex_pkg::ROLE_METHOD;
                end
            end
            ST_URI:
            begin
                if (b == sip_lex_pkg::CH_SP)
                begin
                    state_next = ST_VER_S;
                end
                else if (sip_lex_pkg::is_ctl(b))
                begin
                    verdict = sip_lex_pkg::VERDICT_BAD;
                end
                else
                begin
                    role = sip_lex_pkg::ROLE_URI;
                end
            end
            ST_VER_S:
            begin
                if (b == sip_lex_pkg::CH_S)
                begin
                    state_next = ST_VER_I;
                end
                else
                begin
                    verdict = sip_lex_pkg::VERDICT_BAD;
                end
            end
            ST_VER_I:
            begin
                if (b == sip_lex_pkg::CH_I)
                begin
                    state_next = ST_VER_P;
                end
                else
                begin
                    verdict = sip_lex_pkg::VERDICT_BAD;
                end
            end
            ST_VER_P:
            begin
                if (b == sip_lex_pkg::CH_P)
                begin
                    state_next = ST_VER_SLASH;
                end
                else
                begin
                    verdict = sip_lex_pkg::VERDICT_BAD;
                end
            end
            ST_VER_SLASH:
            begin
                if (b == sip_lex_pkg::CH_SLASH)
                begin
                    major_next = 8'd0;
                    minor_next = 8'd0;
                    state_next = ST_MAJ_START;
                end
                else
                begin
                    verdict = sip_lex_pkg::VERDICT_BAD;
                end
            end
            ST_MAJ_START:
            begin
                if (sip_lex_pkg::is_digit(b))
                begin
                    major_next = sip_lex_pkg::sat_acc(major_cur, b);
                    state_next = ST_MAJ;
                end
                else
                begin
                    verdict = sip_lex_pkg::VERDICT_BAD;
                end
            end
            ST_MAJ:
            begin
                if (b == sip_lex_pkg::CH_DOT)
                begin
                    state_next = ST_MIN_START;
                end
                else if (sip_lex_pkg::is_digit(b))
                begin
                    major_next = sip_lex_pkg::sat_acc(major_cur, b);
                end
                else
                begin
                    verdict = sip_lex_pkg::VERDICT_BAD;
                end
            end
            ST_MIN_START:
            begin
                if (sip_lex_pkg::is_digit(b))
                begin
                    minor_next = sip_lex_pkg::sat_acc(minor_cur, b);
                    state_next = ST_MIN;
                end
                else
                begin
                    verdict = sip_lex_pkg::VERDICT_BAD;
                end
            end
            ST_MIN:
            begin
                if (b == sip_lex_pkg::CH_CR)
                begin
                    // response line still moves on to the line feed
                    state_next = ST_NL1;
                    if (mode_reg)
                    begin
                        verdict = sip_lex_pkg::VERDICT_BAD;
                    end
                end
                else if (b == sip_lex_pkg::CH_SP)
                begin
                    if (mode_reg)
                    begin
                        state_next = ST_STAT1;
                    end
                    else
                    begin
                        verdict = sip_lex_pkg::VERDICT_BAD;
                    end
                end
                else if (sip_lex_pkg::is_digit(b))
                begin
                    minor_next = sip_lex_pkg::sat_acc(minor_cur, b);
                end
                else
                begin
                    verdict = sip_lex_pkg::VERDICT_BAD;
                end
            end
            ST_STAT1, ST_STAT2, ST_STAT3:
            begin
                if (sip_lex_pkg::is_digit(b))
                begin
                    status_next = stat_mod;
                    if (state_cur == ST_STAT1)
                    begin
                        state_next = ST_STAT2;
                    end
                    else if (state_cur == ST_STAT2)
                    begin
                        state_next = ST_STAT3;
                    end
                    else
                    begin
                        state_next = ST_STAT_END;
                    end
                end
                else
                begin
                    verdict = sip_lex_pkg::VERDICT_BAD;
                end
            end
            ST_STAT_END:
            begin
                if (b == sip_lex_pkg::CH_SP)
                begin
                    state_next = ST_REASON;
                end
                else
                begin
                    verdict = sip_lex_pkg::VERDICT_BAD;
                end
            end
            ST_REASON:
            begin
                if (b == sip_lex_pkg::CH_CR)
                begin
                    state_next = ST_NL1;
                end
                else if (b == sip_lex_pkg::CH_SP || sip_lex_pkg::is_token(b))
                begin
                    role = sip_lex_pkg::ROLE_REASON;
                end
                else
                begin
                    verdict = sip_lex_pkg::VERDICT_BAD;
                end
            end
            ST_NL1, ST_NL2:
            begin
                if (b == sip_lex_pkg::CH_LF)
                begin
                    state_next = ST_LINE_START;
                end
                else
                begin
                    verdict = sip_lex_pkg::VERDICT_BAD;
                end
            end
            ST_LINE_START:
            begin
                if (b == sip_lex_pkg::CH_CR)
                begin
                    state_next = ST_NL3;
                end
                else if (seen_cur && (b == sip_lex_pkg::CH_SP || b == sip_lex_pkg::CH_TAB))
                begin
                    state_next = ST_LWS;
                end
                else if (!sip_lex_pkg::is_token(b))
                begin
                    verdict = sip_lex_pkg::VERDICT_BAD;
                end
                else
                begin
                    seen_next  = 1'b1;
                    hstart     = 1'b1;
                    role       = sip_lex_pkg::ROLE_NAME;
                    state_next = ST_NAME;
                end
            end
            ST_LWS:
            begin
                if (b == sip_lex_pkg::CH_CR)
                begin
                    state_next = ST_NL2;
                end
                else if (b == sip_lex_pkg::CH_SP || b == sip_lex_pkg::CH_TAB)
                begin
                    state_next = ST_LWS;
                end
                else if (sip_lex_pkg::is_ctl(b))
                begin
                    verdict = sip_lex_pkg::VERDICT_BAD;
                end
                else
                begin
                    state_next = ST_VALUE;
                    role       = sip_lex_pkg::ROLE_VALUE;
                end
            end
            ST_NAME:
            begin
                if (b == sip_lex_pkg::CH_COLON)
                begin
                    state_next = ST_SPACE;
                end
                else if (!sip_lex_pkg::is_token(b))
                begin
                    verdict = sip_lex_pkg::VERDICT_BAD;
                end
                else
                begin
                    role = sip_lex_pkg::ROLE_NAME;
                end
            end
            ST_SPACE:
            begin
                if (b == sip_lex_pkg::CH_SP)
                begin
                    state_next = ST_VALUE;
                end
                else
                begin
                    verdict = sip_lex_pkg::VERDICT_BAD;
                end
            end
            ST_VALUE:
            begin
                if (b == sip_lex_pkg::CH_CR)
                begin
                    state_next = ST_NL2;
                end
                else if (sip_lex_pkg::is_ctl(b))
                begin
                    verdict = sip_lex_pkg::VERDICT_BAD;
                end
                else
                begin
                    role = sip_lex_pkg::ROLE_VALUE;
                end
            end
            ST_NL3:
            begin
                verdict = (b == sip_lex_pkg::CH_LF) ? sip_lex_pkg::VERDICT_GOOD
                                                    : sip_lex_pkg::VERDICT_BAD;
            end
            default:
            begin
                verdict = sip_lex_pkg::VERDICT_BAD;
            end
        endcase

        rbyte = 8'd0;
        if (role != sip_lex_pkg::ROLE_NONE)
        begin
            rbyte = b;
            if (role == sip_lex_pkg::ROLE_NAME && b >= sip_lex_pkg::CH_UC_A
                && b <= sip_lex_pkg::CH_UC_Z)
            begin
                rbyte = b | sip_lex_pkg::CASE_BIT;
            end
        end

        result_next.verdict        = verdict;
        result_next.byte_role      = role;
        result_next.role_byte      = rbyte;
        result_next.header_start   = hstart;
        result_next.version_major  = major_next;
        result_next.version_minor  = minor_next;
        result_next.status_code    = status_next;
        result_next.bytes_consumed = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_METHOD_START;
            mode_reg         <= 1'b0;
            major_reg        <= 8'd0;
            minor_reg        <= 8'd0;
            status_reg       <= 10'd0;
            seen_reg         <= 1'b0;
            count_reg        <= 32'd0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
            if (take)
            begin
                state_reg        <= state_next;
                major_reg        <= major_next;
                minor_reg        <= minor_next;
                status_reg       <= status_next;
                seen_reg         <= seen_next;
                count_reg        <= count_next;
                result_reg       <= result_next;
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    `ASSERT_ALWAYS(a_bad_has_no_role,
        !result_valid || result.verdict != sip_lex_pkg::VERDICT_BAD
            || result.byte_role == sip_lex_pkg::ROLE_NONE,
        "bad byte carries a role")
    `ASSERT_ALWAYS(a_start_is_name,
        !result_valid || !result.header_start || result.byte_role == sip_lex_pkg::ROLE_NAME,
        "header start outside a header name")
    `ASSERT_ALWAYS(a_status_range, status_reg < 10'd1000, "status accumulator out of range")
    `ASSERT_NEXT(a_take_gives_result, take,
        result_valid && result.bytes_consumed == $past(count_reg) + 32'd1,
        "accepted byte gave no counted result")

endmodule
